// File: design/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg: shared types and constants of the sorted record table
// Record layout, action and status codes, string cutting helper.
// ----------------------------------------------------------------------------
`default_nettype none

package srt_pkg;

    localparam int CAPACITY    = 16;
    localparam int NAME_BYTES  = 8;
    localparam int CLASS_BYTES = 4;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    typedef logic [2:0] action_t;
    localparam action_t ACT_INSERT   = 3'd0;
    localparam action_t ACT_DEL_NUM  = 3'd1;
    localparam action_t ACT_DEL_NAME = 3'd2;
    localparam action_t ACT_MOD_NUM  = 3'd3;
    localparam action_t ACT_MOD_NAME = 3'd4;
    localparam action_t ACT_FIND_NUM = 3'd5;
    localparam action_t ACT_FIND_NAM = 3'd6;
    localparam action_t ACT_DUMP     = 3'd7;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_FULL      = 2'd2;
    localparam status_t ST_EMPTY     = 2'd3;

    // one stored record
    typedef struct packed {
        logic [63:0] name;
        logic [31:0] number;
        logic [31:0] class_label;
        logic        sex;
        logic [6:0]  age;
        logic [1:0]  health;
    } record_t;

    typedef struct packed {
        action_t     action;
        logic [31:0] key_number;
        logic [63:0] key_name;
        logic [63:0] rec_name;
        logic [31:0] rec_number;
        logic        rec_sex;
        logic [6:0]  rec_age;
        logic [31:0] rec_class;
        logic [1:0]  rec_health;
    } in_beat_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] out_name;
        logic [31:0] out_number;
        logic        out_sex;
        logic [6:0]  out_age;
        logic [31:0] out_class;
        logic [1:0]  out_health;
        logic        last;
    } out_beat_t;

    // keep at most nbytes, stopping at first zero byte
    function automatic logic [63:0] cut_string(input logic [63:0] v, input int nbytes);
        logic [63:0] r;
        logic        stop;
        r    = '0;
        stop = 1'b0;
        for (int b = 0; b < 8; b++) begin
            if (b >= nbytes || v[8*b +: 8] == 8'd0)
                stop = 1'b1;
            if (!stop)
                r[8*b +: 8] = v[8*b +: 8];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/srt_if.sv
// ----------------------------------------------------------------------------
// srt_in_if / srt_out_if: valid/ready channels of the sorted record table
// One beat moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface srt_in_if;
    logic              valid;
    logic              ready;
    srt_pkg::in_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface srt_out_if;
    logic               valid;
    logic               ready;
    srt_pkg::out_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/srt_ram.sv
// ----------------------------------------------------------------------------
// srt_ram: record store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srt_ram (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [srt_pkg::IDX_W-1:0] waddr,
    input  srt_pkg::record_t               wdata,
    input  wire logic [srt_pkg::IDX_W-1:0] raddr,
    output srt_pkg::record_t               rdata
);

    srt_pkg::record_t mem [srt_pkg::CAPACITY];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: design/sorted_record_table.sv
// ----------------------------------------------------------------------------
// sorted_record_table: bounded table of records sorted by number
// Sequencer walking a record store (one read, one write port) for search, shift and dump.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | action, keys, replacing record
//  rsp     | out | status, record, last
//
// One request at a time. A search steps through the entries, each one read and
// then compared; each shift moves one entry, read and then written. A modify that
// changes the number runs a delete walk and then an insert walk. A dump reads
// each entry and then presents it as one beat.
// Reset clears the entry count; the store needs no clearing.
// The result register holds while rsp is stalled; insert and dump wait for it.
`default_nettype none

module sorted_record_table (
    input wire logic  clk,
    input wire logic  rst_n,
    srt_in_if.sink    req,
    srt_out_if.source rsp
);

    localparam int IW = srt_pkg::IDX_W;
    localparam int CW = srt_pkg::CNT_W;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SEARCH = 9'b000000010,
        S_LOOK   = 9'b000000100,
        S_DEL_RD = 9'b000001000,
        S_DEL_WR = 9'b000010000,
        S_INS_RD = 9'b000100000,
        S_INS_WR = 9'b001000000,
        S_DUMP   = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    srt_pkg::in_beat_t cmd_reg, cmd_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;     // read pointer
    logic [CW-1:0]     pos_reg, pos_next;     // target slot
    logic              rd_pend_reg, rd_pend_next;
    logic              ovalid_reg, ovalid_next;
    srt_pkg::out_beat_t obeat_reg, obeat_next;
    logic              after_reg, after_next; // insert follows removal (modify)

    logic              we;
    logic [IW-1:0]     waddr, raddr;
    srt_pkg::record_t  wdata, rdata, newrec;
    logic [63:0]       keyname;

    srt_ram u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    always_comb
    begin
        newrec.name        = srt_pkg::cut_string(cmd_reg.rec_name, srt_pkg::NAME_BYTES);
        newrec.number      = cmd_reg.rec_number;
        newrec.class_label = 32'(srt_pkg::cut_string({32'd0, cmd_reg.rec_class},
                                                     srt_pkg::CLASS_BYTES));
        newrec.sex         = cmd_reg.rec_sex;
        newrec.age         = cmd_reg.rec_age;
        newrec.health      = cmd_reg.rec_health;
        keyname            = srt_pkg::cut_string(cmd_reg.key_name, srt_pkg::NAME_BYTES);
    end

    function automatic srt_pkg::out_beat_t mk(input srt_pkg::status_t st,
                                              input srt_pkg::record_t r,
                                              input logic has, input logic lst);
        srt_pkg::out_beat_t o;
        o = '0;
        o.status = st;
        o.last   = lst;
        if (has)
        begin
            o.out_name   = r.name;
            o.out_number = r.number;
            o.out_sex    = r.sex;
            o.out_age    = r.age;
            o.out_class  = r.class_label;
            o.out_health = r.health;
        end
        return o;
    endfunction

    assign req.ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign rsp.valid = ovalid_reg;
    assign rsp.data  = obeat_reg;

    // sequencer
    always_comb
    begin
        logic hit, by_num;
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        rd_pend_next = 1'b0;
        ovalid_next  = ovalid_reg;
        obeat_next   = obeat_reg;
        after_next   = after_reg;
        we           = 1'b0;
        waddr        = pos_reg[IW-1:0];
        wdata        = newrec;
        raddr        = idx_reg[IW-1:0];
        hit          = 1'b0;
        by_num       = (cmd_reg.action == srt_pkg::ACT_DEL_NUM)
                    || (cmd_reg.action == srt_pkg::ACT_MOD_NUM)
                    || (cmd_reg.action == srt_pkg::ACT_FIND_NUM);
        if (ovalid_reg && rsp.ready)
            ovalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    cmd_next   = req.data;
                    idx_next   = '0;
                    after_next = 1'b0;
                    case (req.data.action)
                        srt_pkg::ACT_INSERT:
                        begin
                            if (count_reg == CW'(srt_pkg::CAPACITY))
                            begin
                                obeat_next  = mk(srt_pkg::ST_FULL, rdata, 1'b0, 1'b1);
                                ovalid_next = 1'b1;
                            end
                            else
                                state_next = S_SEARCH;
                        end
                        srt_pkg::ACT_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                obeat_next  = mk(srt_pkg::ST_EMPTY, rdata, 1'b0, 1'b1);
                                ovalid_next = 1'b1;
                            end
                            else
                                state_next = S_DUMP;
                        end
                        default: state_next = S_SEARCH;
                    endcase
                end
            end

            // issue read of entry idx, examine it next cycle
            S_SEARCH:
            begin
                if (idx_reg == count_reg)
                begin
                    if (cmd_reg.action == srt_pkg::ACT_INSERT || after_reg)
                    begin
                        pos_next   = idx_reg;
                        idx_next   = count_reg;
                        state_next = S_INS_RD;
                    end
                    else
                    begin
                        obeat_next  = mk(srt_pkg::ST_NOT_FOUND, rdata, 1'b0, 1'b1);
                        ovalid_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else
                    state_next = S_LOOK;
            end

            S_LOOK:
            begin
                if (cmd_reg.action == srt_pkg::ACT_INSERT || after_reg)
                begin
                    if (!(cmd_reg.rec_number > rdata.number))
                    begin
                        pos_next   = idx_reg;
                        idx_next   = count_reg;
                        state_next = S_INS_RD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SEARCH;
                    end
                end
                else if (by_num && rdata.number > cmd_reg.key_number)
                begin
                    obeat_next  = mk(srt_pkg::ST_NOT_FOUND, rdata, 1'b0, 1'b1);
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    hit = by_num ? (rdata.number == cmd_reg.key_number)
                                 : (rdata.name == keyname);
                    if (!hit)
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SEARCH;
                    end
                    else
                    begin
                        case (cmd_reg.action)
                            srt_pkg::ACT_FIND_NUM, srt_pkg::ACT_FIND_NAM:
                            begin
                                obeat_next  = mk(srt_pkg::ST_OK, rdata, 1'b1, 1'b1);
                                ovalid_next = 1'b1;
                                state_next  = S_IDLE;
                            end
                            srt_pkg::ACT_DEL_NUM, srt_pkg::ACT_DEL_NAME:
                            begin
                                obeat_next  = mk(srt_pkg::ST_OK, rdata, 1'b1, 1'b1);
                                ovalid_next = 1'b1;
                                pos_next    = idx_reg;
                                idx_next    = idx_reg + 1'b1;
                                state_next  = S_DEL_RD;
                            end
                            default:
                            begin
                                // modify: same number rewrites in place
                                if (rdata.number == cmd_reg.rec_number)
                                begin
                                    we          = 1'b1;
                                    waddr       = idx_reg[IW-1:0];
                                    obeat_next  = mk(srt_pkg::ST_OK, newrec, 1'b1, 1'b1);
                                    ovalid_next = 1'b1;
                                    state_next  = S_IDLE;
                                end
                                else
                                begin
                                    after_next = 1'b1;
                                    pos_next   = idx_reg;
                                    idx_next   = idx_reg + 1'b1;
                                    state_next = S_DEL_RD;
                                end
                            end
                        endcase
                    end
                end
            end

            // close the gap: entry idx moves to idx-1
            S_DEL_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    idx_next   = '0;
                    state_next = after_reg ? S_SEARCH : S_IDLE;
                end
                else
                    state_next = S_DEL_WR;
            end

            S_DEL_WR:
            begin
                we         = 1'b1;
                waddr      = pos_reg[IW-1:0];
                wdata      = rdata;
                pos_next   = idx_reg;
                idx_next   = idx_reg + 1'b1;
                state_next = S_DEL_RD;
            end

            // open a gap at pos: entry idx-1 moves to idx
            S_INS_RD:
            begin
                if (idx_reg == pos_reg)
                begin
                    if (!ovalid_reg || rsp.ready)
                    begin
                        we          = 1'b1;
                        waddr       = pos_reg[IW-1:0];
                        count_next  = count_reg + 1'b1;
                        obeat_next  = mk(srt_pkg::ST_OK, newrec, 1'b1, 1'b1);
                        ovalid_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    raddr      = IW'(idx_reg - 1'b1);
                    state_next = S_INS_WR;
                end
            end

            S_INS_WR:
            begin
                we         = 1'b1;
                waddr      = idx_reg[IW-1:0];
                wdata      = rdata;
                idx_next   = idx_reg - 1'b1;
                state_next = S_INS_RD;
            end

            // dump: read idx, present it when the result register frees
            S_DUMP:
            begin
                if (rd_pend_reg && (!ovalid_reg || rsp.ready))
                begin
                    obeat_next  = mk(srt_pkg::ST_OK, rdata, 1'b1,
                                     idx_reg + 1'b1 == count_reg);
                    ovalid_next = 1'b1;
                    if (idx_reg + 1'b1 == count_reg)
                        state_next = S_IDLE;
                    else
                        idx_next = idx_reg + 1'b1;
                end
                else
                    rd_pend_next = rd_pend_reg | 1'b1;
                if (rd_pend_reg && !(!ovalid_reg || rsp.ready))
                    rd_pend_next = 1'b1;
                if (rd_pend_reg && (!ovalid_reg || rsp.ready))
                    rd_pend_next = 1'b0;
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            ovalid_reg  <= 1'b0;
            rd_pend_reg <= 1'b0;
            after_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovalid_reg  <= ovalid_next;
            rd_pend_reg <= rd_pend_next;
            after_reg   <= after_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        obeat_reg <= obeat_next;
    end

endmodule

`default_nettype wire

// File: sim/srt_checker.sv
// ----------------------------------------------------------------------------
// srt_checker: result predictor and comparator for the sorted record table
// Watches the request and result channels, keeps its own sorted table and
// compares every result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module srt_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    srt_in_if.sink    req,
    srt_out_if.sink   rsp,
    output int        fail_count,
    output int        pending
);
    import srt_pkg::*;

    record_t   table_q[$];
    out_beat_t expected_q[$];

    assign pending = expected_q.size();

    function automatic logic [63:0] trim_bytes(logic [63:0] v, int nbytes);
        logic [63:0] r;
        r = '0;
        for (int b = 0; b < nbytes; b++)
        begin
            if (v[8*b +: 8] == 8'd0)
                break;
            r[8*b +: 8] = v[8*b +: 8];
        end
        return r;
    endfunction

    function automatic out_beat_t make_beat(status_t st, record_t r, logic has, logic lst);
        out_beat_t o;
        o = '0;
        o.status = st;
        o.last   = lst;
        if (has)
        begin
            o.out_name   = r.name;
            o.out_number = r.number;
            o.out_sex    = r.sex;
            o.out_age    = r.age;
            o.out_class  = r.class_label;
            o.out_health = r.health;
        end
        return o;
    endfunction

    function automatic int search_number(logic [31:0] key);
        foreach (table_q[i])
        begin
            if (table_q[i].number > key)
                return -1;
            if (table_q[i].number == key)
                return i;
        end
        return -1;
    endfunction

    function automatic int search_name(logic [63:0] key);
        logic [63:0] k;
        k = trim_bytes(key, NAME_BYTES);
        foreach (table_q[i])
            if (table_q[i].name == k)
                return i;
        return -1;
    endfunction

    function automatic int place_sorted(record_t r);
        int pos;
        pos = 0;
        while (pos < table_q.size() && r.number > table_q[pos].number)
            pos++;
        table_q.insert(pos, r);
        return pos;
    endfunction

    // work out the result beats for one accepted request
    task automatic predict_action(in_beat_t b);
        record_t nr;
        int      at;
        nr.name        = trim_bytes(b.rec_name, NAME_BYTES);
        nr.number      = b.rec_number;
        nr.class_label = 32'(trim_bytes({32'd0, b.rec_class}, CLASS_BYTES));
        nr.sex         = b.rec_sex;
        nr.age         = b.rec_age;
        nr.health      = b.rec_health;
        case (b.action)
            ACT_INSERT:
            begin
                if (table_q.size() >= CAPACITY)
                    expected_q.push_back(make_beat(ST_FULL, nr, 1'b0, 1'b1));
                else
                begin
                    at = place_sorted(nr);
                    expected_q.push_back(make_beat(ST_OK, table_q[at], 1'b1, 1'b1));
                end
            end
            ACT_DUMP:
            begin
                if (table_q.size() == 0)
                    expected_q.push_back(make_beat(ST_EMPTY, nr, 1'b0, 1'b1));
                foreach (table_q[i])
                    expected_q.push_back(make_beat(ST_OK, table_q[i], 1'b1,
                                                   i == table_q.size() - 1));
            end
            default:
            begin
                if (b.action == ACT_DEL_NUM || b.action == ACT_MOD_NUM
                    || b.action == ACT_FIND_NUM)
                    at = search_number(b.key_number);
                else
                    at = search_name(b.key_name);
                if (at < 0)
                    expected_q.push_back(make_beat(ST_NOT_FOUND, nr, 1'b0, 1'b1));
                else if (b.action == ACT_DEL_NUM || b.action == ACT_DEL_NAME)
                begin
                    expected_q.push_back(make_beat(ST_OK, table_q[at], 1'b1, 1'b1));
                    table_q.delete(at);
                end
                else if (b.action == ACT_MOD_NUM || b.action == ACT_MOD_NAME)
                begin
                    if (table_q[at].number != nr.number)
                    begin
                        table_q.delete(at);
                        at = place_sorted(nr);
                    end
                    else
                        table_q[at] = nr;
                    expected_q.push_back(make_beat(ST_OK, table_q[at], 1'b1, 1'b1));
                end
                else
                    expected_q.push_back(make_beat(ST_OK, table_q[at], 1'b1, 1'b1));
            end
        endcase
    endtask

    task automatic compare_beat(out_beat_t got);
        out_beat_t want;
        if (expected_q.size() == 0)
        begin
            $error("unexpected result beat: %p", got);
            fail_count++;
            return;
        end
        want = expected_q.pop_front();
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
        end
        if (got.out_name !== want.out_name)
        begin
            $error("out_name: expected %h, got %h", want.out_name, got.out_name);
            fail_count++;
        end
        if (got.out_number !== want.out_number)
        begin
            $error("out_number: expected %h, got %h", want.out_number, got.out_number);
            fail_count++;
        end
        if (got.out_sex !== want.out_sex)
        begin
            $error("out_sex: expected %0d, got %0d", want.out_sex, got.out_sex);
            fail_count++;
        end
        if (got.out_age !== want.out_age)
        begin
            $error("out_age: expected %0d, got %0d", want.out_age, got.out_age);
            fail_count++;
        end
        if (got.out_class !== want.out_class)
        begin
            $error("out_class: expected %h, got %h", want.out_class, got.out_class);
            fail_count++;
        end
        if (got.out_health !== want.out_health)
        begin
            $error("out_health: expected %0d, got %0d", want.out_health, got.out_health);
            fail_count++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            fail_count++;
        end
    endtask

    initial fail_count = 0;

    // sample both channels at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
                compare_beat(rsp.data);
            if (req.valid && req.ready)
                predict_action(req.data);
        end
    end

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the sorted record table
// Directed table operations, then random action sequences over a small name
// and number pool so that searches hit, with random idle on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import srt_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_BEATS = 470;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    bit   timed_out = 1'b0;
    bit   sink_calm = 1'b0;

    srt_in_if  req();
    srt_out_if rsp();

    sorted_record_table u_dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));
    srt_checker u_checker (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
                           .fail_count(fail_count), .pending(pending));

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT && !timed_out)
        begin
            timed_out <= 1'b1;
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random stall before each beat, sometimes none
    initial
    begin
        int gap;
        rsp.ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            gap = sink_calm ? 0 : $urandom_range(0, 11);
            if (gap != 0)
            begin
                rsp.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk iff rsp.valid);
        end
    end

    function automatic logic [63:0] pool_name(int i);
        // short names with zero padding, some with junk after the zero byte
        logic [63:0] n;
        n = 64'h0;
        n[7:0]  = 8'h41 + i[7:0];
        n[15:8] = (i % 3 == 0) ? 8'h00 : 8'h62;
        if ($urandom_range(0, 3) == 0)
            n[63:24] = 40'({$urandom, $urandom});
        return n;
    endfunction

    task automatic send_beat(in_beat_t b, bit calm);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.data  <= b;
        req.valid <= 1'b1;
        @(posedge clk iff req.ready);
    endtask

    function automatic in_beat_t rand_beat(bit wild);
        in_beat_t b;
        b = $bits(in_beat_t)'({$urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom});
        b.action = action_t'($urandom_range(0, 7));
        if (!wild)
        begin
            b.key_number = $urandom_range(0, 9);
            b.rec_number = $urandom_range(0, 9);
            b.key_name   = pool_name($urandom_range(0, 7));
            b.rec_name   = pool_name($urandom_range(0, 7));
        end
        return b;
    endfunction

    initial
    begin
        in_beat_t b;
        req.valid = 1'b0;
        req.data  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table cases
        b = '0;
        b.action = ACT_DUMP;       send_beat(b, 1'b0);
        b.action = ACT_FIND_NUM;   send_beat(b, 1'b0);
        b.action = ACT_DEL_NAME;   send_beat(b, 1'b0);
        b.action = ACT_MOD_NUM;    send_beat(b, 1'b0);
        // extremes, equal numbers, fill past capacity
        for (int i = 0; i < CAPACITY + 2; i++)
        begin
            b = '1;
            b.action     = ACT_INSERT;
            b.rec_number = (i % 4 == 0) ? 32'hFFFF_FFFF : (i % 4 == 1) ? 32'd0 : 32'd5;
            b.rec_name   = (i == 1) ? 64'h0 : (i == 2) ? 64'hFF00_FF41 : pool_name(i);
            b.rec_class  = (i == 3) ? 32'h11_00_22_33 : 32'hFFFF_FFFF;
            b.rec_health = i[1:0];
            b.rec_sex    = i[0];
            b.rec_age    = i[0] ? 7'h7F : 7'h00;
            send_beat(b, i > 8);
        end
        b = '0;
        b.action = ACT_DUMP;       send_beat(b, 1'b1);
        b.action = ACT_FIND_NUM; b.key_number = 32'hFFFF_FFFF; send_beat(b, 1'b0);
        b.action = ACT_FIND_NAM; b.key_name = 64'hAA00_0000_FF41; send_beat(b, 1'b0);
        b.action = ACT_MOD_NAME; b.rec_number = 32'd5; b.rec_name = 64'h55; send_beat(b, 1'b0);
        b.action = ACT_MOD_NUM; b.key_number = 32'd5; b.rec_number = 32'd5; send_beat(b, 1'b0);
        b.action = ACT_DEL_NUM; b.key_number = 32'd3; send_beat(b, 1'b0);

        // random: mostly pool-based keys so searches hit
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            sink_calm = (n / 60) % 3 == 2;
            send_beat(rand_beat($urandom_range(0, 9) == 0), sink_calm);
        end
        req.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
